FILE: design/point_vector_transform_4x4_top_defines.svh
// Assertion macros for the point and vector transform block.
`ifndef POINT_VECTOR_TRANSFORM_4X4_TOP_DEFINES_SVH
`define POINT_VECTOR_TRANSFORM_4X4_TOP_DEFINES_SVH

// Checked only outside reset.
`define PVT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PVT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/pvt_pkg.sv
// Package with shared constants and reset values for the transform block.
`timescale 1ns / 1ps
package pvt_pkg;

  localparam int NUM_REGS = 8;
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int REG_W = 64;
  localparam int COORD_W = 32;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  localparam int REG_E0_E1 = 0;
  localparam int REG_E4_E5 = 2;
  localparam int REG_E10_E11 = 5;
  localparam int REG_E14_E15 = 7;

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_DZ,
    MODE_DIV
  } mode_t;

  // Identity matrix: 1.0 in elements 0, 5, 10 and 15.
  function automatic logic [REG_W-1:0] reg_reset(input int idx, input int frac);
    logic [REG_W-1:0] one;
    one = REG_W'(1) << frac;
    case (idx)
      REG_E0_E1, REG_E10_E11: reg_reset = one;
      REG_E4_E5, REG_E14_E15: reg_reset = one << 32;
      default: reg_reset = '0;
    endcase
  endfunction

endpackage

FILE: design/pvt_dot.sv
// One matrix row: three products, then the floored sum plus translation.
`timescale 1ns / 1ps
module pvt_dot #(
  parameter int DW = pvt_pkg::DATA_WIDTH_DEF,
  parameter int FB = pvt_pkg::FRAC_BITS_DEF,
  parameter int RW = 2 * DW + 3 - FB
) (
  input  logic                 clk,
  input  logic                 adv,
  input  logic signed [DW-1:0] a0,
  input  logic signed [DW-1:0] a1,
  input  logic signed [DW-1:0] a2,
  input  logic signed [DW-1:0] v0,
  input  logic signed [DW-1:0] v1,
  input  logic signed [DW-1:0] v2,
  input  logic signed [DW-1:0] t,
  output logic signed [RW-1:0] r
);
  import pvt_pkg::*;

  localparam int PW = 2 * DW;
  localparam int SW = PW + 2;

  logic signed [PW-1:0] p0_r, p1_r, p2_r;
  logic signed [DW-1:0] t_r;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] sum_fl;
  logic signed [RW-1:0] r_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p0_r <= a0 * v0;
      p1_r <= a1 * v1;
      p2_r <= a2 * v2;
      t_r  <= t;
    end
  end

  // Floor of the exact sum equals the sum of floored parts plus floored remainders.
  always_comb begin
    sum    = SW'(p0_r) + SW'(p1_r) + SW'(p2_r);
    sum_fl = sum >>> FB;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_r <= RW'(sum_fl) + RW'(t_r);
    end
  end

  assign r = r_r;

endmodule

FILE: design/pvt_div_lane.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow check.
`timescale 1ns / 1ps
module pvt_div_lane #(
  parameter int DW = pvt_pkg::DATA_WIDTH_DEF,
  parameter int FB = pvt_pkg::FRAC_BITS_DEF,
  parameter int MW = 2 * DW + 3 - FB
) (
  input  logic          clk,
  input  logic          adv,
  input  logic [MW-1:0] ax,
  input  logic [MW-1:0] aw,
  input  logic          neg,
  output logic [DW:0]   q,
  output logic          ovf,
  output logic          neg_o
);
  import pvt_pkg::*;

  localparam int CW = MW + FB + DW + 1;
  localparam int NSTEP = DW + 1;

  logic [CW-1:0] rem_r [0:NSTEP];
  logic [MW-1:0] dvs_r [0:NSTEP];
  logic [DW:0]   q_r   [0:NSTEP];
  logic          ovf_r [0:NSTEP];
  logic          neg_r [0:NSTEP];
  logic [CW-1:0] num;
  logic [CW-1:0] lim;

  assign num = CW'(ax) << FB;
  assign lim = CW'(aw) << NSTEP;

  // A quotient of 2^(DW+1) or more is clamped at the output.
  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= num;
      dvs_r[0] <= aw;
      q_r[0]   <= '0;
      ovf_r[0] <= (num >= lim);
      neg_r[0] <= neg;
    end
  end

  for (genvar j = 1; j <= NSTEP; j++) begin : g_step
    localparam int K = NSTEP - j;
    logic [CW-1:0] trial;
    logic          take;
    assign trial = CW'(dvs_r[j-1]) << K;
    assign take  = rem_r[j-1] >= trial;
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[j] <= take ? rem_r[j-1] - trial : rem_r[j-1];
        q_r[j]   <= q_r[j-1] | ((DW+1)'(take) << K);
        dvs_r[j] <= dvs_r[j-1];
        ovf_r[j] <= ovf_r[j-1];
        neg_r[j] <= neg_r[j-1];
      end
    end
  end

  assign q     = q_r[NSTEP];
  assign ovf   = ovf_r[NSTEP];
  assign neg_o = neg_r[NSTEP];

endmodule

FILE: design/point_vector_transform_4x4_top.sv
// Top level of the 4x4 homogeneous point and direction transform.
//
//  Channel | Handshake           | Payload
//  --------+---------------------+------------------------------------------
//  input   | in_valid / in_ready | func, in_x, in_y, in_z
//  result  | out_valid/out_ready | out_x, out_y, out_z, divide_by_zero,
//          |                     | saturated
//  config  | cfg_we              | cfg_index, cfg_data (matrix row pairs)
//
// One item is accepted per clock while the output is not stalled; each item
// passes the input, product, sum and classify registers, the divider and the
// output register. The depth is set by the divider, one quotient bit per stage.
// Reset (synchronous, active low) empties the pipeline and loads the identity
// matrix. A stall at the output freezes every stage at once, so nothing is lost
// or repeated; in_ready is low exactly while a result waits to be taken.
`timescale 1ns / 1ps
module point_vector_transform_4x4_top #(
  parameter int DATA_WIDTH = pvt_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = pvt_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           func,
  input  logic [pvt_pkg::COORD_W-1:0]    in_x,
  input  logic [pvt_pkg::COORD_W-1:0]    in_y,
  input  logic [pvt_pkg::COORD_W-1:0]    in_z,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pvt_pkg::COORD_W-1:0]    out_x,
  output logic [pvt_pkg::COORD_W-1:0]    out_y,
  output logic [pvt_pkg::COORD_W-1:0]    out_z,
  output logic                           divide_by_zero,
  output logic                           saturated,
  input  logic                           cfg_we,
  input  logic [pvt_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [pvt_pkg::REG_W-1:0]      cfg_data
);
  import pvt_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int RW = 2 * DW + 3 - FRAC_BITS;
  localparam int NDIV = DW + 2;       // divider register stages
  localparam int NV = 4 + NDIV;       // stages ahead of the output register

  localparam logic signed [RW-1:0] R_MAX = {{(RW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [RW-1:0] R_MIN = ~R_MAX;
  localparam logic signed [RW-1:0] R_ONE = {{(RW-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic signed [DW-1:0] D_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] D_MIN = ~D_MAX;
  localparam logic [DW:0]          Q_HALF = {2'b01, {(DW-1){1'b0}}};

  typedef struct packed {
    mode_t                     mode;
    logic                      pflag;
    logic signed [2:0][DW-1:0] pres;
  } side_t;

  // Matrix registers and element view.
  logic [REG_W-1:0]     mat_r [NUM_REGS];
  logic signed [DW-1:0] m [16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        mat_r[i] <= reg_reset(i, FRAC_BITS);
      end
    end else if (cfg_we) begin
      mat_r[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      m[k] = mat_r[k/2][(k%2)*32 +: DW];
    end
  end

  // Global advance: every stage moves when the output register is free.
  logic            adv;
  logic [NV-1:0]   vpipe_r;
  logic            out_valid_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vpipe_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vpipe_r     <= {vpipe_r[NV-2:0], in_valid};
      out_valid_r <= vpipe_r[NV-1];
    end
  end

  // Stage 1: input register.
  logic                 func1_r;
  logic signed [DW-1:0] x1_r, y1_r, z1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      func1_r <= func;
      x1_r    <= in_x[DW-1:0];
      y1_r    <= in_y[DW-1:0];
      z1_r    <= in_z[DW-1:0];
    end
  end

  // Stages 2 and 3: products and dot sums. Vector mode drops the translation.
  logic signed [DW-1:0] t_row [4];
  logic signed [RW-1:0] r3 [4];
  logic                 func2_r, func3_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_row[i] = func1_r ? '0 : m[4*i+3];
    end
    t_row[3] = m[15];
  end

  for (genvar i = 0; i < 4; i++) begin : g_row
    pvt_dot #(.DW(DW), .FB(FRAC_BITS), .RW(RW)) u_dot (
      .clk (clk),
      .adv (adv),
      .a0  (m[4*i]),
      .a1  (m[4*i+1]),
      .a2  (m[4*i+2]),
      .v0  (x1_r),
      .v1  (y1_r),
      .v2  (z1_r),
      .t   (t_row[i]),
      .r   (r3[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      func2_r <= func1_r;
      func3_r <= func2_r;
    end
  end

  // Stage 4: classify the item, prepare magnitudes for the dividers and the
  // results of the cases that need no divide.
  side_t         side4;
  logic [RW-1:0] ax4 [3];
  logic [2:0]    neg4;
  logic [RW-1:0] aw4;
  logic          w_neg;
  logic [2:0]    clamp;

  always_comb begin
    w_neg = r3[3] < 0;
    if (func3_r || r3[3] == R_ONE) begin
      side4.mode = MODE_PASS;
    end else if (r3[3] == '0) begin
      side4.mode = MODE_DZ;
    end else begin
      side4.mode = MODE_DIV;
    end
    for (int i = 0; i < 3; i++) begin
      clamp[i] = (r3[i] > R_MAX) || (r3[i] < R_MIN);
      if (side4.mode == MODE_DZ) begin
        // Zero w: each output goes to the bound that matches its sign.
        if (r3[i] > 0) begin
          side4.pres[i] = D_MAX;
        end else if (r3[i] < 0) begin
          side4.pres[i] = D_MIN;
        end else begin
          side4.pres[i] = '0;
        end
      end else if (r3[i] > R_MAX) begin
        side4.pres[i] = D_MAX;
      end else if (r3[i] < R_MIN) begin
        side4.pres[i] = D_MIN;
      end else begin
        side4.pres[i] = r3[i][DW-1:0];
      end
      ax4[i]  = r3[i] < 0 ? RW'(-r3[i]) : RW'(r3[i]);
      neg4[i] = (r3[i] < 0) ^ w_neg;
    end
    side4.pflag = (side4.mode == MODE_PASS) && (|clamp);
    // Items that do not divide still run through with a harmless divisor.
    if (side4.mode == MODE_DIV) begin
      aw4 = w_neg ? RW'(-r3[3]) : RW'(r3[3]);
    end else begin
      aw4 = {{(RW-1){1'b0}}, 1'b1};
    end
  end

  side_t         side4_r;
  logic [RW-1:0] ax4_r [3];
  logic [2:0]    neg4_r;
  logic [RW-1:0] aw4_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      side4_r <= side4;
      ax4_r   <= ax4;
      neg4_r  <= neg4;
      aw4_r   <= aw4;
    end
  end

  // Divider lanes, with the side data delayed to match.
  logic [DW:0] q_d [3];
  logic [2:0]  ovf_d;
  logic [2:0]  neg_d;
  side_t       side_d_r [NDIV];

  for (genvar i = 0; i < 3; i++) begin : g_div
    pvt_div_lane #(.DW(DW), .FB(FRAC_BITS), .MW(RW)) u_div (
      .clk   (clk),
      .adv   (adv),
      .ax    (ax4_r[i]),
      .aw    (aw4_r),
      .neg   (neg4_r[i]),
      .q     (q_d[i]),
      .ovf   (ovf_d[i]),
      .neg_o (neg_d[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_d_r[0] <= side4_r;
      for (int j = 1; j < NDIV; j++) begin
        side_d_r[j] <= side_d_r[j-1];
      end
    end
  end

  // Output stage: pick the divided result or the precomputed one, then clamp.
  side_t                     side_o;
  logic signed [2:0][DW-1:0] res;
  logic [2:0]                dsat;
  logic                      sat_o;

  always_comb begin
    side_o = side_d_r[NDIV-1];
    for (int i = 0; i < 3; i++) begin
      dsat[i] = 1'b0;
      if (ovf_d[i]) begin
        dsat[i] = 1'b1;
        res[i]  = neg_d[i] ? D_MIN : D_MAX;
      end else if (neg_d[i]) begin
        if (q_d[i] > Q_HALF) begin
          dsat[i] = 1'b1;
          res[i]  = D_MIN;
        end else begin
          res[i] = DW'(-q_d[i]);
        end
      end else if (q_d[i] >= Q_HALF) begin
        dsat[i] = 1'b1;
        res[i]  = D_MAX;
      end else begin
        res[i] = q_d[i][DW-1:0];
      end
      if (side_o.mode != MODE_DIV) begin
        res[i] = side_o.pres[i];
      end
    end
    sat_o = (side_o.mode == MODE_DIV) ? (|dsat) : side_o.pflag;
  end

  logic signed [2:0][DW-1:0] res_r;
  logic                      dz_r;
  logic                      sat_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
      dz_r  <= side_o.mode == MODE_DZ;
      sat_r <= sat_o;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_x          = COORD_W'(res_r[0]);
  assign out_y          = COORD_W'(res_r[1]);
  assign out_z          = COORD_W'(res_r[2]);
  assign divide_by_zero = dz_r;
  assign saturated      = sat_r;

endmodule

FILE: design/pvt_checker.sv
// Port-level checker for the transform block, bound to the top level.
`timescale 1ns / 1ps
`include "point_vector_transform_4x4_top_defines.svh"
module pvt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [pvt_pkg::COORD_W-1:0]   out_x,
  input logic [pvt_pkg::COORD_W-1:0]   out_y,
  input logic [pvt_pkg::COORD_W-1:0]   out_z,
  input logic                          divide_by_zero,
  input logic                          saturated
);

  // A result that waits holds its payload.
  `PVT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z), "result changed while stalled")

  // The pipeline takes no item while its output stalls.
  `PVT_ASSERT(a_stall_blocks, out_valid && !out_ready |-> !in_ready, "input taken during output stall")

  // A zero-w result never reports clamping.
  `PVT_ASSERT(a_dz_no_sat, out_valid && divide_by_zero |-> !saturated, "saturated with divide by zero")

  // Reset empties the pipeline.
  `PVT_ASSERT_ALWAYS(a_reset_empty, $past(!rst_n) |-> !out_valid, "result valid after reset")

endmodule

bind point_vector_transform_4x4_top pvt_checker u_pvt_checker (.*);

FILE: tb/testbench.sv
// Self-checking testbench for the 4x4 point and direction transform block.
`timescale 1ns / 1ps
module testbench;
  import pvt_pkg::*;

  // Function codes of the input item.
  localparam bit FN_POINT  = 1'b0;
  localparam bit FN_VECTOR = 1'b1;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam logic [31:0] ONE_Q = 32'h0001_0000;
  localparam logic [31:0] MAX_Q = 32'h7fff_ffff;
  localparam logic [31:0] MIN_Q = 32'h8000_0000;

  // Matrix shapes used by the phases of the run.
  typedef enum int {
    MK_IDENTITY, MK_ZERO_W, MK_DIV2, MK_ALL_MAX, MK_ALL_MIN,
    MK_AFFINE, MK_PERSP, MK_WILD
  } mat_kind_t;

  // One transformed result, as it leaves the block.
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        dz;
    logic        sat;
  } xform_t;

  // One row of the directed table. Rows with known = 1 carry a typed-in result.
  typedef struct {
    mat_kind_t   mk;
    bit          f;
    logic [31:0] x, y, z;
    bit          known;
    xform_t      res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic func = FN_POINT;
  logic [COORD_W-1:0] in_x = '0, in_y = '0, in_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [COORD_W-1:0] out_x, out_y, out_z;
  logic divide_by_zero, saturated;
  logic cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  point_vector_transform_4x4_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .in_x(in_x), .in_y(in_y), .in_z(in_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .divide_by_zero(divide_by_zero), .saturated(saturated),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // The testbench's own copy of the matrix registers, and the next matrix to load.
  logic [REG_W-1:0] mat_reg[NUM_REGS];
  logic signed [31:0] mat_next[16];

  xform_t pending_xf[$];
  dir_row_t dir_tab[$];
  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int matrices_loaded = 0;
  int dz_seen = 0;
  int sat_seen = 0;
  int burst_left = 0;

  // ---------------------------------------------------------------------------
  // Predictor: exact dot products, floor to Q16.16, then unit-w or vector pass, zero-w
  // saturation by sign, or the truncating divide.
  // ---------------------------------------------------------------------------
  function automatic logic signed [31:0] elem_at(input int k);
    logic [REG_W-1:0] r;
    r = mat_reg[k / 2];
    return (k % 2) ? r[63:32] : r[31:0];
  endfunction

  function automatic logic signed [63:0] row_dot(input int row, input bit with_t,
      input logic signed [31:0] vx, input logic signed [31:0] vy,
      input logic signed [31:0] vz);
    logic signed [95:0] acc, a, b;
    acc = '0;
    a = elem_at(4 * row);     b = vx; acc += a * b;
    a = elem_at(4 * row + 1); b = vy; acc += a * b;
    a = elem_at(4 * row + 2); b = vz; acc += a * b;
    acc = acc >>> FRAC;
    if (with_t) begin
      a = elem_at(4 * row + 3);
      acc += a;
    end
    return acc[63:0];
  endfunction

  function automatic logic [31:0] clamp_q(input logic signed [127:0] v, inout logic flag);
    logic signed [127:0] hi, lo;
    hi = $signed(MAX_Q);
    lo = -hi - 1;
    if (v > hi) begin
      flag = 1'b1;
      return MAX_Q;
    end
    if (v < lo) begin
      flag = 1'b1;
      return MIN_Q;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] divide_q(input logic signed [63:0] n,
      input logic signed [63:0] w, inout logic flag);
    logic signed [127:0] sn, sw, sv;
    logic [127:0] ax, aw, mag;
    bit neg;
    sn = n;
    sw = w;
    neg = (sn < 0) != (sw < 0);
    ax = (sn < 0) ? -sn : sn;
    aw = (sw < 0) ? -sw : sw;
    // An integer part that does not fit clamps at once.
    if (ax / aw >= (128'd1 << (32 - FRAC))) begin
      flag = 1'b1;
      return neg ? MIN_Q : MAX_Q;
    end
    mag = (ax << FRAC) / aw;
    sv = neg ? -$signed(mag) : $signed(mag);
    return clamp_q(sv, flag);
  endfunction

  function automatic xform_t transform_item(input bit f, input logic signed [31:0] vx,
      input logic signed [31:0] vy, input logic signed [31:0] vz);
    xform_t res;
    logic signed [63:0] r[3];
    logic signed [63:0] w;
    logic flag;
    flag = 1'b0;
    res.dz = 1'b0;
    for (int i = 0; i < 3; i++) r[i] = row_dot(i, f == FN_POINT, vx, vy, vz);
    w = row_dot(3, 1'b1, vx, vy, vz);
    if (f == FN_VECTOR || w == 64'sd65536) begin
      res.x = clamp_q(r[0], flag);
      res.y = clamp_q(r[1], flag);
      res.z = clamp_q(r[2], flag);
    end else if (w == 0) begin
      // Zero w: each output goes to the end of the range its numerator points to.
      res.dz = 1'b1;
      res.x = (r[0] > 0) ? MAX_Q : (r[0] < 0) ? MIN_Q : '0;
      res.y = (r[1] > 0) ? MAX_Q : (r[1] < 0) ? MIN_Q : '0;
      res.z = (r[2] > 0) ? MAX_Q : (r[2] < 0) ? MIN_Q : '0;
    end else begin
      res.x = divide_q(r[0], w, flag);
      res.y = divide_q(r[1], w, flag);
      res.z = divide_q(r[2], w, flag);
    end
    res.sat = flag;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result is compared with the oldest
  // expectation, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      xform_t got, want;
      got = '{out_x, out_y, out_z, divide_by_zero, saturated};
      results_seen++;
      if (divide_by_zero) dz_seen++;
      if (saturated) sat_seen++;
      if (pending_xf.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result x=%h y=%h z=%h dz=%b sat=%b",
                   out_x, out_y, out_z, divide_by_zero, saturated);
      end else begin
        want = pending_xf.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"ERROR: result %0d: expected x=%h y=%h z=%h dz=%b sat=%b,",
                      " got x=%h y=%h z=%h dz=%b sat=%b"},
                     results_seen, want.x, want.y, want.z, want.dz, want.sat,
                     got.x, got.y, got.z, got.dz, got.sat);
        end
      end
    end
  end

  // The receiver switches at random among three stall habits: always ready, coin
  // flip, or mostly stalled.
  int stall_mode = 0;
  int stall_cnt = 0;
  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 128 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Sends one item in bursts with random gaps. Returns at the edge that accepted
  // it, with valid still high so that the next item can follow back to back.
  task automatic send_item(input bit f, input logic [31:0] x, input logic [31:0] y,
      input logic [31:0] z, input bit known, input xform_t res);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    func <= f;
    in_x <= x;
    in_y <= y;
    in_z <= z;
    do @(posedge clk); while (!in_ready);
    pending_xf.push_back(known ? res : transform_item(f, x, y, z));
    items_sent++;
    burst_left--;
  endtask

  // Holds the sender off until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_xf.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_small();
    return $signed($urandom_range(0, 8 << FRAC)) - $signed(4 << FRAC);
  endfunction

  task automatic set_matrix(input mat_kind_t mk);
    for (int k = 0; k < 16; k++) mat_next[k] = (k % 5 == 0) ? ONE_Q : '0;
    case (mk)
      MK_ZERO_W: begin
        for (int k = 0; k < 12; k++) mat_next[k] = rand_small();
        mat_next[15] = '0;
      end
      MK_DIV2: begin
        mat_next[12] = ONE_Q;
        mat_next[15] = ONE_Q << 1;
      end
      MK_ALL_MAX: for (int k = 0; k < 16; k++) mat_next[k] = MAX_Q;
      MK_ALL_MIN: for (int k = 0; k < 16; k++) mat_next[k] = MIN_Q;
      MK_AFFINE: for (int k = 0; k < 12; k++) mat_next[k] = rand_small();
      MK_PERSP: for (int k = 0; k < 16; k++) mat_next[k] = rand_small();
      MK_WILD: for (int k = 0; k < 16; k++) mat_next[k] = $urandom;
      default: ;
    endcase
  endtask

  // Writes all eight registers from mat_next, one per clock, while idle.
  task automatic load_matrix(input mat_kind_t mk);
    logic [REG_W-1:0] word;
    set_matrix(mk);
    for (int r = 0; r < NUM_REGS; r++) begin
      word = {mat_next[2 * r + 1], mat_next[2 * r]};
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= r[REG_IDX_W-1:0];
      cfg_data <= word;
      mat_reg[r] = word;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    matrices_loaded++;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0, 1: return rand_small() <<< 4;
      2: return rand_small();
      3: return $urandom;
      default: begin
        case ($urandom_range(0, 4))
          0: return MAX_Q;
          1: return MIN_Q;
          2: return ONE_Q;
          3: return '1;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  task automatic add_row(input mat_kind_t mk, input bit f, input logic [31:0] x,
      input logic [31:0] y, input logic [31:0] z, input bit known, input xform_t res);
    dir_row_t row;
    row.mk = mk; row.f = f; row.x = x; row.y = y; row.z = z;
    row.known = known; row.res = res;
    dir_tab.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    mat_kind_t cur_mk;
    mat_kind_t rnd_mk[10];

    mat_reg_t_init();

    // Identity after reset: w is exactly 1.0, so every item passes through.
    add_row(MK_IDENTITY, FN_POINT, '0, '0, '0, 1, '{'0, '0, '0, 0, 0});
    add_row(MK_IDENTITY, FN_POINT, MAX_Q, MIN_Q, ONE_Q, 1, '{MAX_Q, MIN_Q, ONE_Q, 0, 0});
    add_row(MK_IDENTITY, FN_VECTOR, MIN_Q, MAX_Q, '1, 1, '{MIN_Q, MAX_Q, '1, 0, 0});
    add_row(MK_IDENTITY, FN_POINT, '1, 32'd1, 32'h1234_5678, 1,
            '{'1, 32'd1, 32'h1234_5678, 0, 0});
    add_row(MK_IDENTITY, FN_VECTOR, 32'h5555_5555, 32'haaaa_aaaa, '0, 1,
            '{32'h5555_5555, 32'haaaa_aaaa, '0, 0, 0});
    // Zero w row: points saturate by the sign of each numerator, vectors do not.
    add_row(MK_ZERO_W, FN_POINT, '0, '0, '0, 0, '0);
    add_row(MK_ZERO_W, FN_POINT, ONE_Q, -ONE_Q, MAX_Q, 0, '0);
    add_row(MK_ZERO_W, FN_POINT, MIN_Q, MAX_Q, 32'd1, 0, '0);
    add_row(MK_ZERO_W, FN_VECTOR, ONE_Q, -ONE_Q, MAX_Q, 0, '0);
    // w = x + 2.0: ordinary divide, unit w at x = -1.0, zero w at x = -2.0.
    add_row(MK_DIV2, FN_POINT, ONE_Q, ONE_Q << 1, 32'h0003_0000, 0, '0);
    add_row(MK_DIV2, FN_POINT, -ONE_Q, ONE_Q << 3, 32'h0000_8000, 0, '0);
    add_row(MK_DIV2, FN_POINT, -(ONE_Q << 1), ONE_Q, -ONE_Q, 0, '0);
    add_row(MK_DIV2, FN_POINT, MAX_Q, MIN_Q, 32'd7, 0, '0);
    add_row(MK_DIV2, FN_POINT, 32'hfffe_0001, MAX_Q, MIN_Q, 0, '0);
    add_row(MK_DIV2, FN_VECTOR, MAX_Q, MIN_Q, ONE_Q, 0, '0);
    // Extreme elements: mostly overflow and saturation; a zero vector still gives zero.
    add_row(MK_ALL_MAX, FN_POINT, MAX_Q, MAX_Q, MAX_Q, 0, '0);
    add_row(MK_ALL_MAX, FN_VECTOR, MIN_Q, MIN_Q, MIN_Q, 0, '0);
    add_row(MK_ALL_MAX, FN_POINT, ONE_Q, '0, '0, 0, '0);
    add_row(MK_ALL_MAX, FN_VECTOR, '0, '0, '0, 1, '{'0, '0, '0, 0, 0});
    add_row(MK_ALL_MIN, FN_POINT, MIN_Q, MAX_Q, '1, 0, '0);
    add_row(MK_ALL_MIN, FN_VECTOR, MIN_Q, MIN_Q, MIN_Q, 0, '0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    cur_mk = MK_IDENTITY;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].mk != cur_mk) begin
        drain();
        load_matrix(dir_tab[i].mk);
        cur_mk = dir_tab[i].mk;
      end
      send_item(dir_tab[i].f, dir_tab[i].x, dir_tab[i].y, dir_tab[i].z,
                dir_tab[i].known, dir_tab[i].res);
    end

    // Random phases, each under a fresh matrix. Midway through each one the
    // sender holds off until the pipeline has emptied.
    rnd_mk = '{MK_AFFINE, MK_PERSP, MK_ZERO_W, MK_WILD, MK_ALL_MIN,
               MK_PERSP, MK_ALL_MAX, MK_AFFINE, MK_IDENTITY, MK_PERSP};
    foreach (rnd_mk[p]) begin
      drain();
      load_matrix(rnd_mk[p]);
      for (int n = 0; n < 133; n++) begin
        if (n == 66) drain();
        send_item(1'($urandom_range(0, 1)), rand_coord(), rand_coord(), rand_coord(),
                  0, '0);
      end
    end

    drain();
    repeat (50) @(posedge clk);
    $display("Ran %0d items under %0d matrix loads: %0d results, %0d zero-w, %0d saturated.",
             items_sent, matrices_loaded, results_seen, dz_seen, sat_seen);
    $display("Random phases covered affine, perspective, zero-w, extreme and random matrices.");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches in total.", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

  // Identity matrix, as the block holds it after reset.
  function automatic void mat_reg_t_init();
    for (int r = 0; r < NUM_REGS; r++) mat_reg[r] = reg_reset(r, FRAC);
  endfunction

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("Timeout with %0d results still expected.", pending_xf.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
